### rtl/rte_pkg.sv
package rte_pkg;

    // Request codes.
    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_FIND   = 3'd2;
    localparam logic [2:0] REQ_TOUCH  = 3'd3;
    localparam logic [2:0] REQ_EXPIRE = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_REPLACED = 3'd3;
    localparam logic [2:0] ST_EVICTED  = 3'd4;
    localparam logic [2:0] ST_EXPIRED  = 3'd5;
    localparam logic [2:0] ST_NONE_DUE = 3'd6;

    // Configuration register indexes.
    localparam logic REG_HOLD_TIME  = 1'b0;
    localparam logic REG_EMPTY_ADDR = 1'b1;

    // Most expired entries reported by one expire request.
    localparam int MAX_RESULTS = 16;
    localparam int GONE_AW     = $clog2(MAX_RESULTS);
    localparam int GONE_CW     = $clog2(MAX_RESULTS + 1);

    // One route entry as kept in the table memory.
    typedef struct packed {
        logic [15:0] key;
        logic [15:0] next_hop;
        logic [7:0]  hop_count;
        logic [31:0] dest_seq;
        logic        seq_known;
        logic        route_ok;
        logic [31:0] expiry;
    } t_entry;

    // Flags from the shared compare unit.
    typedef struct packed {
        logic eq;
        logic lt;
        logic older;
        logic due;
    } t_cmp;

endpackage

### rtl/route_table_engine.sv
// Channel   Direction  Handshake                 Word
// request   in         start, busy               i_req_type .. i_now
// result    out        o_valid (one cycle)       o_status .. o_last
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Each request scans the filled slots once through the entry memory's
// single read port, one slot a cycle. Entries are moved where needed to
// keep the table sorted, a write or touch then stores its entry, and a
// result ends the request; an expire shows one result per reported entry.
// Reset is synchronous and active low; it empties the table at once.
// Results are shown for one cycle each and cannot be stalled.
module route_table_engine #(
    parameter int TABLE_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_dest_addr,
    input  logic [15:0] i_next_hop,
    input  logic [7:0]  i_hop_count,
    input  logic [31:0] i_dest_seq,
    input  logic        i_seq_known,
    input  logic        i_route_ok,
    input  logic [31:0] i_expiry,
    input  logic [31:0] i_now,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_addr_out,
    output logic [15:0] o_next_hop_out,
    output logic [7:0]  o_hop_count_out,
    output logic [31:0] o_dest_seq_out,
    output logic        o_seq_known_out,
    output logic        o_route_ok_out,
    output logic [31:0] o_expiry_out,
    output logic [4:0]  o_occupancy,
    output logic        o_last
);
    import rte_pkg::*;

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]   r_state;
    logic [2:0]   r_op;
    logic [15:0]  r_addr;
    logic [31:0]  r_now;
    t_entry       r_new;
    logic [31:0]  r_hold;
    logic [15:0]  r_empty;
    logic [CW-1:0] r_fill;

    // Scan state.
    logic [CW-1:0] r_ptr;
    logic          r_vld;
    logic [AW-1:0] r_vidx;
    logic          r_hit;
    logic [AW-1:0] r_hidx;
    t_entry        r_match;
    logic [CW-1:0] r_lt;
    logic [AW-1:0] r_st;
    logic [31:0]   r_stexp;
    logic [15:0]   r_stkey;

    // Expire compaction and report buffer.
    logic [CW-1:0]      r_w;
    logic [GONE_CW-1:0] r_n;
    logic [GONE_CW-1:0] r_e;
    logic [15:0]        r_gone [MAX_RESULTS];

    // Shift sequencer.
    logic [AW-1:0] r_mdst;
    logic          r_mup;
    logic [CW-1:0] r_mcnt;
    logic          r_pend;
    logic [AW-1:0] r_pdst;
    logic          r_doput;
    logic [AW-1:0] r_put_addr;
    t_entry        r_put_data;

    // Pending result.
    logic [2:0] r_res_st;
    t_entry     r_res;

    // Decision taken at the end of the scan.
    logic [2:0]    n_res_st;
    t_entry        n_res;
    logic          n_doput;
    logic [2:0]    n_state;
    logic [AW-1:0] n_put_addr;
    t_entry        n_put_data;
    logic [AW-1:0] n_mdst;
    logic          n_mup;
    logic [CW-1:0] n_mcnt;
    logic [CW-1:0] n_fill;

    t_entry        w_rd;
    t_cmp          w_cmp;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_msrc;
    logic          w_take;
    logic          w_scan_done;
    logic          w_full;

    rte_mem #(.DEPTH(TABLE_SIZE), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    rte_cmp u_cmp (
        .i_entry    (w_rd),
        .i_addr     (r_addr),
        .i_best_exp (r_stexp),
        .i_now      (r_now),
        .o_cmp      (w_cmp)
    );

    assign busy        = (r_state != S_IDLE);
    assign w_msrc      = r_mup ? (r_mdst - AW'(1)) : (r_mdst + AW'(1));
    assign w_take      = w_cmp.due && (r_n < GONE_CW'(MAX_RESULTS));
    assign w_scan_done = (r_ptr == r_fill) && !r_vld;
    assign w_full      = (r_fill == CW'(TABLE_SIZE));

    // Memory port selection.
    always_comb begin
        w_raddr = r_ptr[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_put_addr;
        w_wdata = r_put_data;
        unique case (r_state)
            S_SCAN: begin
                w_raddr = r_ptr[AW-1:0];
                w_waddr = r_w[AW-1:0];
                w_wdata = w_rd;
                w_we    = r_vld && (r_op == REQ_EXPIRE) && !w_take
                          && (r_w != CW'(r_vidx));
            end
            S_MOVE: begin
                w_raddr = w_msrc;
                w_waddr = r_pdst;
                w_wdata = w_rd;
                w_we    = r_pend;
            end
            S_PUT: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= 32'd1000;
            r_empty <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HOLD_TIME:  r_hold  <= i_cfg_data;
                REG_EMPTY_ADDR: r_empty <= i_cfg_data[15:0];
                default:        r_hold  <= r_hold;
            endcase
        end
    end

    // Report buffer for expired addresses.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_vld && r_op == REQ_EXPIRE && w_take) begin
            r_gone[r_n[GONE_AW-1:0]] <= w_rd.key;
        end
    end

    // Result, table update and next state once the scan is over.
    always_comb begin
        n_res      = '0;
        n_res_st   = ST_MISS;
        n_doput    = 1'b0;
        n_state    = S_DONE;
        n_put_addr = r_put_addr;
        n_put_data = r_put_data;
        n_mdst     = r_mdst;
        n_mup      = r_mup;
        n_mcnt     = r_mcnt;
        n_fill     = r_fill;
        case (r_op)
            REQ_WRITE: begin
                n_put_data = r_new;
                n_doput    = 1'b1;
                n_state    = S_MOVE;
                if (r_hit) begin
                    n_res_st   = ST_REPLACED;
                    n_put_addr = r_hidx;
                    n_mcnt     = '0;
                end else if (!w_full) begin
                    n_res_st   = ST_INSERTED;
                    n_mdst     = r_fill[AW-1:0];
                    n_mup      = 1'b1;
                    n_mcnt     = r_fill - r_lt;
                    n_put_addr = r_lt[AW-1:0];
                    n_fill     = r_fill + CW'(1);
                end else begin
                    n_res_st  = ST_EVICTED;
                    n_res.key = r_stkey;
                    n_mdst    = r_st;
                    if (CW'(r_st) < r_lt) begin
                        n_mup      = 1'b0;
                        n_mcnt     = r_lt - CW'(1) - CW'(r_st);
                        n_put_addr = AW'(r_lt - CW'(1));
                    end else begin
                        n_mup      = 1'b1;
                        n_mcnt     = CW'(r_st) - r_lt;
                        n_put_addr = r_lt[AW-1:0];
                    end
                end
            end
            REQ_REMOVE: begin
                if (r_hit) begin
                    n_res_st = ST_DONE;
                    n_mdst   = r_hidx;
                    n_mup    = 1'b0;
                    n_mcnt   = r_fill - CW'(1) - CW'(r_hidx);
                    n_fill   = r_fill - CW'(1);
                    n_state  = S_MOVE;
                end
            end
            REQ_FIND: begin
                if (r_hit) begin
                    n_res_st = ST_DONE;
                    n_res    = r_match;
                end else begin
                    n_res.key       = r_empty;
                    n_res.next_hop  = r_empty;
                    n_res.hop_count = 8'd1;
                end
            end
            REQ_TOUCH: begin
                if (r_hit) begin
                    n_res_st          = ST_DONE;
                    n_put_addr        = r_hidx;
                    n_put_data        = r_match;
                    n_put_data.expiry = r_now + r_hold;
                    n_state           = S_PUT;
                end
            end
            REQ_EXPIRE: begin
                n_fill = r_w;
                if (r_n != '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_res_st = ST_NONE_DUE;
                end
            end
            default: begin
                n_res_st = ST_MISS;
            end
        endcase
    end

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_vld   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_req_type;
                        r_addr   <= i_dest_addr;
                        r_now    <= i_now;
                        r_new    <= '{key: i_dest_addr, next_hop: i_next_hop,
                                      hop_count: i_hop_count, dest_seq: i_dest_seq,
                                      seq_known: i_seq_known, route_ok: i_route_ok,
                                      expiry: i_expiry};
                        r_ptr    <= '0;
                        r_vld    <= 1'b0;
                        r_hit    <= 1'b0;
                        r_lt     <= '0;
                        r_w      <= '0;
                        r_n      <= '0;
                        r_e      <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Issue the next read; inspect the word read last cycle.
                    if (r_ptr != r_fill) begin
                        r_vidx <= r_ptr[AW-1:0];
                        r_ptr  <= r_ptr + CW'(1);
                        r_vld  <= 1'b1;
                    end else begin
                        r_vld <= 1'b0;
                    end
                    if (r_vld) begin
                        if (r_op == REQ_EXPIRE) begin
                            if (w_take) begin
                                r_n <= r_n + GONE_CW'(1);
                            end else begin
                                r_w <= r_w + CW'(1);
                            end
                        end else begin
                            if (w_cmp.eq) begin
                                r_hit   <= 1'b1;
                                r_hidx  <= r_vidx;
                                r_match <= w_rd;
                            end
                            if (w_cmp.lt) begin
                                r_lt <= r_lt + CW'(1);
                            end
                            if (r_vidx == '0 || w_cmp.older) begin
                                r_st    <= r_vidx;
                                r_stexp <= w_rd.expiry;
                                r_stkey <= w_rd.key;
                            end
                        end
                    end
                    if (w_scan_done) begin
                        r_res      <= n_res;
                        r_res_st   <= n_res_st;
                        r_doput    <= n_doput;
                        r_pend     <= 1'b0;
                        r_state    <= n_state;
                        r_put_addr <= n_put_addr;
                        r_put_data <= n_put_data;
                        r_mdst     <= n_mdst;
                        r_mup      <= n_mup;
                        r_mcnt     <= n_mcnt;
                        r_fill     <= n_fill;
                    end
                end
                S_MOVE: begin
                    // Read the source slot, write it in the next cycle.
                    if (r_mcnt != '0) begin
                        r_pend <= 1'b1;
                        r_pdst <= r_mdst;
                        r_mdst <= w_msrc;
                        r_mcnt <= r_mcnt - CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= r_doput ? S_PUT : S_DONE;
                        end
                    end
                end
                S_PUT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    r_e <= r_e + GONE_CW'(1);
                    if (r_e + GONE_CW'(1) == r_n) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result word.
    always_comb begin
        o_valid         = 1'b0;
        o_status        = ST_DONE;
        o_addr_out      = '0;
        o_next_hop_out  = '0;
        o_hop_count_out = '0;
        o_dest_seq_out  = '0;
        o_seq_known_out = 1'b0;
        o_route_ok_out  = 1'b0;
        o_expiry_out    = '0;
        o_last          = 1'b0;
        o_occupancy     = 5'(r_fill);
        if (r_state == S_DONE) begin
            o_valid         = 1'b1;
            o_status        = r_res_st;
            o_addr_out      = r_res.key;
            o_next_hop_out  = r_res.next_hop;
            o_hop_count_out = r_res.hop_count;
            o_dest_seq_out  = r_res.dest_seq;
            o_seq_known_out = r_res.seq_known;
            o_route_ok_out  = r_res.route_ok;
            o_expiry_out    = r_res.expiry;
            o_last          = 1'b1;
        end else if (r_state == S_EMIT) begin
            o_valid    = 1'b1;
            o_status   = ST_EXPIRED;
            o_addr_out = r_gone[r_e[GONE_AW-1:0]];
            o_last     = (r_e + GONE_CW'(1) == r_n);
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_SIZE))
        else $error("fill count above table size");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while idle");
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_EXPIRED) |-> o_last)
        else $error("single result without last mark");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !busy)
        else $error("block still busy after last result");
`endif

endmodule

### rtl/rte_mem.sv
module rte_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  rte_pkg::t_entry     i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output rte_pkg::t_entry     o_rdata
);
    import rte_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rte_cmp.sv
module rte_cmp (
    input  rte_pkg::t_entry i_entry,
    input  logic [15:0]     i_addr,
    input  logic [31:0]     i_best_exp,
    input  logic [31:0]     i_now,
    output rte_pkg::t_cmp   o_cmp
);
    import rte_pkg::*;

    // Key match and order, eviction age and expiry test on one entry.
    always_comb begin
        o_cmp.eq    = (i_entry.key == i_addr);
        o_cmp.lt    = (i_entry.key < i_addr);
        o_cmp.older = (i_entry.expiry < i_best_exp);
        o_cmp.due   = (i_entry.expiry != 32'd0) && (i_entry.expiry <= i_now);
    end

endmodule
